[rtl/i2a_pkg.sv]
package i2a_pkg;

  // width of the value port and width actually converted
  localparam int unsigned InWidth    = 64;
  localparam int unsigned ValueWidth = 64;

  // digit counts for the widest value in each radix
  localparam int unsigned DecDigits = (ValueWidth * 30103) / 100000 + 1;
  localparam int unsigned HexDigits = (ValueWidth + 3) / 4;
  localparam int unsigned NumDigits = DecDigits;
  localparam int unsigned DigBits   = 4 * NumDigits;
  localparam int unsigned CntWidth  = $clog2(NumDigits + 1);
  localparam int unsigned BitWidth  = $clog2(ValueWidth);

  // radix select codes
  localparam logic CmdDec = 1'b0;
  localparam logic CmdHex = 1'b1;

  localparam logic [6:0] AsciiZero = 7'h30;
  localparam logic [6:0] AsciiA    = 7'h61;

  typedef struct packed {
    logic [InWidth-1:0] value;
    logic               command;
  } i2a_in_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
  } i2a_out_t;

  // one hex or bcd digit to its ascii character
  function automatic logic [6:0] digit_to_ascii(input logic [3:0] dig);
    logic [6:0] res;
    if (dig < 4'd10) begin
      res = AsciiZero + {3'b000, dig};
    end else begin
      res = AsciiA + {3'b000, dig} - 7'd10;
    end
    return res;
  endfunction

endpackage

[rtl/integer_to_ascii_digits_core.sv]
// Converts one unsigned value to its ASCII digits, decimal or lower-case hex,
// and sends them out most significant digit first without leading zeros; the
// final digit of each run carries last, and zero gives the single digit '0'.
// The block takes one item at a time and is not ready until the last digit of
// the run has been taken. A decimal item runs a shift-and-add-3 loop over all
// ValueWidth input bits that builds the BCD digits one input bit per cycle; a
// hex item loads its nibbles directly. Leading zeros are then dropped one
// digit per cycle (up to 19 decimal, 15 hex) before the run moves to output,
// and each digit is held on the output until it has been taken.
module integer_to_ascii_digits_core
  import i2a_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  i2a_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output i2a_out_t out_data_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StConv  = 2'd1;
  localparam logic [1:0] StStrip = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [DigBits-1:0]    dig_q, dig_d;
  logic [ValueWidth-1:0] val_q, val_d;
  logic [BitWidth-1:0]   bit_q, bit_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [DigBits-1:0]    dabble;
  logic [3:0]            top_dig;

  assign top_dig = dig_q[DigBits-1 -: 4];

  // add 3 to every bcd digit of five or more, then shift in the next bit
  always_comb begin
    logic [DigBits-1:0] adj;
    adj = dig_q;
    for (int i = 0; i < NumDigits; i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      end
    end
    dabble = {adj[DigBits-2:0], val_q[ValueWidth-1]};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    val_d   = val_q;
    bit_d   = bit_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          val_d = in_data_i.value[ValueWidth-1:0];
          bit_d = BitWidth'(ValueWidth - 1);
          if (in_data_i.command == CmdHex) begin
            // hex digits left aligned in the digit register
            dig_d   = DigBits'(in_data_i.value[ValueWidth-1:0]) << (4 * (NumDigits - HexDigits));
            cnt_d   = CntWidth'(HexDigits);
            state_d = StStrip;
          end else begin
            dig_d   = '0;
            cnt_d   = CntWidth'(DecDigits);
            state_d = StConv;
          end
        end
      end
      StConv: begin
        dig_d = dabble;
        val_d = {val_q[ValueWidth-2:0], 1'b0};
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = StStrip;
        end
      end
      StStrip: begin
        if (top_dig == 4'd0 && cnt_q > CntWidth'(1)) begin
          dig_d = {dig_q[DigBits-5:0], 4'd0};
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          dig_d = {dig_q[DigBits-5:0], 4'd0};
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CntWidth'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    val_q <= val_d;
  end

  // item handshakes
  assign in_ready_o            = (state_q == StIdle);
  assign out_valid_o           = (state_q == StEmit);
  assign out_data_o.digit_char = digit_to_ascii(top_dig);
  assign out_data_o.last       = (cnt_q == CntWidth'(1));

endmodule

[tb/integer_to_ascii_digits_core_test.sv]
module integer_to_ascii_digits_core_test;
  import i2a_pkg::*;

  localparam int          MaxRun     = 20;
  localparam int          CycleLimit = 600000;
  localparam int          TailCycles = 200;
  localparam int          RandPerPh  = 90;
  localparam logic [6:0]  ChZero     = 7'h30;
  localparam logic [6:0]  ChLowerA   = 7'h61;
  localparam logic [63:0] ValueMask  =
    (ValueWidth >= 64) ? 64'hffff_ffff_ffff_ffff : ((64'd1 << ValueWidth) - 64'd1);

  // one conversion request waiting to be sent
  typedef struct {
    i2a_in_t payload;
    int      phase;
    bit      drain;
  } conv_request_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid    = 1'b0;
  i2a_in_t  in_data     = '0;
  logic     out_ready   = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  i2a_out_t out_data_o;

  conv_request_t conv_requests[$];
  i2a_out_t      digit_runs[$];

  int send_idle_pct [4] = '{0, 61, 0, 37};
  int recv_stall_pct[4] = '{0, 0, 61, 37};
  int cur_phase   = 0;
  int cycle_cnt   = 0;
  int mismatches  = 0;
  int digits_seen = 0;
  int dec_items   = 0;
  int hex_items   = 0;

  integer_to_ascii_digits_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // digit run of one accepted value, most significant digit first
  function automatic void push_digit_run(i2a_in_t item);
    logic [63:0] num;
    logic [63:0] base;
    logic [3:0]  lsd_first[MaxRun];
    int          cnt;
    i2a_out_t    dig;
    num  = item.value & ValueMask;
    base = (item.command == CmdHex) ? 64'd16 : 64'd10;
    cnt  = 0;
    if (num == 64'd0) begin
      lsd_first[0] = 4'd0;
      cnt = 1;
    end else begin
      while (num != 64'd0 && cnt < MaxRun) begin
        lsd_first[cnt] = 4'(num % base);
        cnt++;
        num = num / base;
      end
    end
    for (int k = cnt - 1; k >= 0; k--) begin
      if (lsd_first[k] < 4'd10) begin
        dig.digit_char = ChZero + 7'(lsd_first[k]);
      end else begin
        dig.digit_char = ChLowerA + 7'(lsd_first[k]) - 7'd10;
      end
      dig.last = (k == 0);
      digit_runs.push_back(dig);
    end
  endfunction

  task automatic add_request(logic [63:0] value, logic cmd, int phase, bit drain);
    conv_request_t req;
    req.payload.value   = value;
    req.payload.command = cmd;
    req.phase = phase;
    req.drain = drain;
    conv_requests.push_back(req);
  endtask

  // driver: presents queued values, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    conv_request_t head;
    logic          launch;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      launch = 1'b0;
      if (in_valid && in_ready_o) begin
        push_digit_run(in_data);
        if (in_data.command == CmdHex) begin
          hex_items++;
        end else begin
          dec_items++;
        end
      end
      if (!in_valid || in_ready_o) begin
        if (conv_requests.size() > 0) begin
          head = conv_requests[0];
          launch = 1'b1;
          // hold off until the block has drained
          if (head.drain && digit_runs.size() != 0) begin
            launch = 1'b0;
          end
          if (launch && $urandom_range(99) < send_idle_pct[head.phase]) begin
            launch = 1'b0;
          end
          if (launch) begin
            void'(conv_requests.pop_front());
            in_data   <= head.payload;
            cur_phase <= head.phase;
          end
        end
        in_valid <= launch;
      end
    end
  end

  // monitor: checks each digit against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    i2a_out_t exp_dig;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        digits_seen++;
        if (digit_runs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected digit char=%h last=%b", $time,
                   out_data_o.digit_char, out_data_o.last);
        end else begin
          exp_dig = digit_runs.pop_front();
          if (out_data_o.digit_char !== exp_dig.digit_char) begin
            mismatches++;
            $display("%0t: digit_char expected %h actual %h", $time,
                     exp_dig.digit_char, out_data_o.digit_char);
          end
          if (out_data_o.last !== exp_dig.last) begin
            mismatches++;
            $display("%0t: last expected %b actual %b", $time,
                     exp_dig.last, out_data_o.last);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [63:0] val;
    logic [63:0] pow;
    logic        cmd;

    // edges of both radixes
    add_request(64'd0, CmdDec, 0, 1'b0);
    add_request(64'd0, CmdHex, 0, 1'b0);
    add_request(64'd1, CmdDec, 0, 1'b0);
    add_request(64'd9, CmdDec, 0, 1'b0);
    add_request(64'd10, CmdDec, 0, 1'b0);
    add_request(64'd9, CmdHex, 0, 1'b0);
    add_request(64'd10, CmdHex, 0, 1'b0);
    add_request(64'd15, CmdHex, 0, 1'b0);
    add_request(64'd16, CmdHex, 0, 1'b0);
    add_request(64'd100, CmdDec, 0, 1'b0);
    add_request(64'hffff_ffff_ffff_ffff, CmdDec, 0, 1'b0);
    add_request(64'hffff_ffff_ffff_ffff, CmdHex, 0, 1'b0);
    add_request(64'd10000000000000000000, CmdDec, 0, 1'b0);
    add_request(64'd9999999999999999999, CmdDec, 0, 1'b0);
    add_request(64'hfedc_ba98_7654_3210, CmdHex, 0, 1'b0);
    add_request(64'h0123_4567_89ab_cdef, CmdHex, 0, 1'b0);
    add_request(64'h8000_0000_0000_0000, CmdDec, 0, 1'b0);
    add_request(64'h8000_0000_0000_0000, CmdHex, 0, 1'b0);
    add_request(64'haaaa_aaaa_aaaa_aaaa, CmdHex, 0, 1'b0);
    add_request(64'h5555_5555_5555_5555, CmdDec, 0, 1'b0);

    // random values of assorted magnitude, four phases of send idling and output stalls
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RandPerPh; n++) begin
        cmd = $urandom_range(1) ? CmdHex : CmdDec;
        case ($urandom_range(9))
          0: val = 64'd0;
          1: val = 64'hffff_ffff_ffff_ffff >> $urandom_range(63);
          2, 3: begin
            pow = 64'd1;
            repeat ($urandom_range(19)) pow = pow * 64'd10;
            val = pow - 64'($urandom_range(1));
          end
          default: val = {$urandom(), $urandom()} >> $urandom_range(63);
        endcase
        add_request(val, cmd, ph, n == 0);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (conv_requests.size() != 0 || in_valid || digit_runs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (digit_runs.size() != 0) begin
      mismatches++;
      $display("%0t: %0d digits never arrived", $time, digit_runs.size());
    end

    $display("converted %0d decimal and %0d hex values, %0d digits checked",
             dec_items, hex_items, digits_seen);
    $display("covered zero, full-width, power-of-ten edges and random stalls on both sides");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
